// ===== rtl/core/spd_pkg.sv =====
`default_nettype none

package spd_pkg;

  // Fixed limits of the frame geometry
  localparam int MAX_ROWS     = 32768;
  localparam int MAX_COLS     = 8192;
  localparam int MAX_DIFF_DEF = 256;

  // Field widths
  localparam int SAMPLE_W   = 32;
  localparam int PHASE_W    = 16;
  localparam int DIFF_W     = 17;
  localparam int ROW_W      = 15;
  localparam int COL_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT     = 3'd0,
    REG_COL_COUNT     = 3'd1,
    REG_START_ROW     = 3'd2,
    REG_END_ROW       = 3'd3,
    REG_DIFF_DISTANCE = 3'd4,
    REG_EXTRACT_STEP  = 3'd5
  } cfg_reg_t;

  // Clamped frame geometry seen by the row sequencer
  typedef struct packed {
    logic               active;
    logic [15:0]        rows_run;
    logic [13:0]        cols;
    logic [13:0]        cols_run;
    logic [ROW_W-1:0]   start;
    logic signed [16:0] last_ex;
    logic [8:0]         spacing;
    logic [15:0]        step;
  } geom_t;

  // Result metadata traveling with a beat down the pipeline
  typedef struct packed {
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] column_index;
    logic             frame_last;
  } meta_t;

endpackage

`default_nettype wire

// ===== rtl/core/spd_if.sv =====
`default_nettype none

interface spd_in_if;
  import spd_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_word;
  modport source (output valid, output sample_word, input ready);
  modport sink (input valid, input sample_word, output ready);
endinterface

interface spd_out_if;
  import spd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DIFF_W-1:0] diff_phase;
  logic [ROW_W-1:0]         out_row;
  logic [COL_W-1:0]         column_index;
  logic                     frame_last;
  modport source (output valid, output diff_phase, output out_row, output column_index,
                  output frame_last, input ready);
  modport sink (input valid, input diff_phase, input out_row, input column_index,
                input frame_last, output ready);
endinterface

interface spd_cfg_if;
  import spd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spd_cfg_regs.sv =====
`default_nettype none

module spd_cfg_regs
  import spd_pkg::*;
#(
  parameter int MAX_DIFF = MAX_DIFF_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_idx,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output logic                       restart,
  output geom_t                      geom
);

  logic [15:0] row_count_r;
  logic [13:0] col_count_r;
  logic [14:0] start_row_r;
  logic [15:0] end_row_r;
  logic [8:0]  diff_distance_r;
  logic [15:0] extract_step_r;

  logic [15:0]        rows;
  logic [15:0]        rows_run;
  logic [13:0]        cols;
  logic [8:0]         spacing;
  logic [15:0]        step;
  logic [ROW_W-1:0]   start;
  logic [15:0]        end_c;
  logic signed [16:0] rows_less_dist;

  // Decode register writes; unknown indexes are dropped without a restart
  always_comb begin
    restart = 1'b0;
    if (wr_en) begin
      unique case (cfg_reg_t'(wr_idx)) inside
        REG_ROW_COUNT, REG_COL_COUNT, REG_START_ROW,
        REG_END_ROW, REG_DIFF_DISTANCE, REG_EXTRACT_STEP: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r     <= 16'd1024;
      col_count_r     <= 14'd1;
      start_row_r     <= 15'd0;
      end_row_r       <= 16'd32768;
      diff_distance_r <= 9'd1;
      extract_step_r  <= 16'd1;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_idx))
        REG_ROW_COUNT:     row_count_r     <= wr_data;
        REG_COL_COUNT:     col_count_r     <= wr_data[13:0];
        REG_START_ROW:     start_row_r     <= wr_data[14:0];
        REG_END_ROW:       end_row_r       <= wr_data;
        REG_DIFF_DISTANCE: diff_distance_r <= wr_data[8:0];
        REG_EXTRACT_STEP:  extract_step_r  <= wr_data;
        default: ;
      endcase
    end
  end

  // Clamp the geometry
  always_comb begin
    rows     = ({1'b0, row_count_r} > 17'(MAX_ROWS)) ? 16'(MAX_ROWS) : row_count_r;
    cols     = ({1'b0, col_count_r} > 15'(MAX_COLS)) ? 14'(MAX_COLS) : col_count_r;
    rows_run = (rows == 16'd0) ? 16'd1 : rows;
    spacing  = (diff_distance_r == 9'd0) ? 9'd1 :
               ((32'(diff_distance_r) > MAX_DIFF) ? 9'(MAX_DIFF) : diff_distance_r);
    step     = (extract_step_r == 16'd0) ? 16'd1 : extract_step_r;
    start    = ({1'b0, start_row_r} > (rows_run - 16'd1)) ?
               ROW_W'(rows_run - 16'd1) : start_row_r;
    end_c    = (end_row_r < {1'b0, start}) ? {1'b0, start} :
               ((end_row_r > rows_run) ? rows_run : end_row_r);
    rows_less_dist = $signed({1'b0, rows_run}) - $signed({8'd0, spacing});

    geom.active   = (rows != 16'd0) && (cols != 14'd0);
    geom.rows_run = rows_run;
    geom.cols     = cols;
    geom.cols_run = (cols == 14'd0) ? 14'd1 : cols;
    geom.start    = start;
    geom.last_ex  = ($signed({1'b0, end_c}) < rows_less_dist) ?
                    $signed({1'b0, end_c}) : rows_less_dist;
    geom.spacing  = spacing;
    geom.step     = step;
  end

endmodule

`default_nettype wire

// ===== rtl/core/spd_ctrl.sv =====
`default_nettype none

module spd_ctrl
  import spd_pkg::*;
#(
  parameter int MAX_DIFF = MAX_DIFF_DEF,
  localparam int PW = (MAX_DIFF > 1) ? $clog2(MAX_DIFF) : 1
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   accept,
  input  wire logic   restart,
  input  wire geom_t  geom,
  output logic        hit,
  output meta_t       meta,
  output logic [PW-1:0] waddr,
  output logic [PW-1:0] raddr
);

  localparam int XW = ((PW > 9) ? PW : 9) + 1;

  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [14:0]      dec_r;
  logic [ROW_W-1:0] orc_r;
  logic [PW-1:0]    wp_r;

  logic [ROW_W-1:0] row_nxt;
  logic [COL_W-1:0] col_nxt;
  logic [14:0]      dec_nxt;
  logic [ROW_W-1:0] orc_nxt;

  logic [ROW_W-1:0]   base;
  logic               qual;
  logic [15:0]        dec_inc;
  logic signed [17:0] next_base;
  logic [XW-1:0]      wp_x;
  logic [XW-1:0]      dist_x;

  // Qualify the base row this sample closes
  always_comb begin
    base      = row_r - ROW_W'(geom.spacing);
    qual      = geom.active && (row_r >= ROW_W'(geom.spacing)) && (base >= geom.start) &&
                ($signed({2'b00, base}) < geom.last_ex);
    hit       = qual && (dec_r == 15'd0);
    next_base = $signed({3'b000, base}) + $signed({2'b00, geom.step});
    meta.out_row      = orc_r;
    meta.column_index = col_r;
    meta.frame_last   = (({1'b0, col_r} + 14'd1) == geom.cols) &&
                        (next_base >= 18'(geom.last_ex));
  end

  // Ring addresses: write the current sample, read the one spacing rows back
  always_comb begin
    wp_x   = XW'(wp_r);
    dist_x = XW'(geom.spacing);
    waddr  = wp_r;
    raddr  = (wp_x >= dist_x) ? PW'(wp_x - dist_x) : PW'(wp_x + XW'(MAX_DIFF) - dist_x);
  end

  // Advance row, decimation and column counters
  always_comb begin
    dec_inc = {1'b0, dec_r} + 16'd1;
    dec_nxt = dec_r;
    orc_nxt = hit ? orc_r + ROW_W'(1) : orc_r;
    col_nxt = col_r;
    row_nxt = row_r + ROW_W'(1);
    if (qual) begin
      dec_nxt = (dec_inc >= geom.step) ? 15'd0 : dec_inc[14:0];
    end
    if (({1'b0, row_r} + 16'd1) >= geom.rows_run) begin
      row_nxt = '0;
      dec_nxt = '0;
      orc_nxt = '0;
      col_nxt = (({1'b0, col_r} + 14'd1) >= geom.cols_run) ? '0 : col_r + COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
      dec_r <= '0;
      orc_r <= '0;
      wp_r  <= '0;
    end else begin
      if (restart) begin
        row_r <= '0;
        col_r <= '0;
        dec_r <= '0;
        orc_r <= '0;
      end else if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
        dec_r <= dec_nxt;
        orc_r <= orc_nxt;
      end
      if (accept) begin
        wp_r <= (32'(wp_r) == MAX_DIFF - 1) ? '0 : wp_r + PW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spd_ring.sv =====
`default_nettype none

module spd_ring
  import spd_pkg::*;
#(
  parameter int MAX_DIFF = MAX_DIFF_DEF,
  localparam int PW = (MAX_DIFF > 1) ? $clog2(MAX_DIFF) : 1
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [PW-1:0]      waddr,
  input  wire logic [PHASE_W-1:0] wdata,
  input  wire logic [PW-1:0]      raddr,
  output logic [PHASE_W-1:0]      rdata
);

  logic [PHASE_W-1:0] mem [MAX_DIFF];
  logic [PHASE_W-1:0] rdata_r;

  // Read the old entry before this beat overwrites it
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r    <= mem[raddr];
      mem[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/core/spd_pipe.sv =====
`default_nettype none

module spd_pipe
  import spd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               accept,
  input  wire logic               hit,
  input  wire meta_t              meta,
  input  wire logic [PHASE_W-1:0] phase,
  input  wire logic [PHASE_W-1:0] old_phase,
  output logic                    in_ready,
  spd_out_if.source               out_ch
);

  logic               s1_valid_r;
  logic [PHASE_W-1:0] s1_phase_r;
  meta_t              s1_meta_r;

  logic                     out_valid_r;
  logic signed [DIFF_W-1:0] diff_r;
  meta_t                    out_meta_r;

  logic                     advance;
  logic signed [DIFF_W-1:0] diff_nxt;

  assign advance  = !out_valid_r || out_ch.ready;
  assign in_ready = !s1_valid_r || advance;
  assign diff_nxt = $signed({s1_phase_r[PHASE_W-1], s1_phase_r}) -
                    $signed({old_phase[PHASE_W-1], old_phase});

  // Stage one: hold the sample and its metadata alongside the ring read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= hit;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_phase_r <= phase;
      s1_meta_r  <= meta;
    end
  end

  // Output register: subtract and hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      diff_r     <= diff_nxt;
      out_meta_r <= s1_meta_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.diff_phase   = diff_r;
  assign out_ch.out_row      = out_meta_r.out_row;
  assign out_ch.column_index = out_meta_r.column_index;
  assign out_ch.frame_last   = out_meta_r.frame_last;

endmodule

`default_nettype wire

// ===== rtl/core/spatial_diff_phase_decimator.sv =====
// Path: a result passes through the stage-one register and then the output register once the
// sample that completes it is accepted. Throughput: one sample per cycle; the ring is a
// single-write, single-read memory accessed once per beat, and the output register stalls the
// pipe only when it is full and not taken. Reset (rst_n, synchronous, active low) restores the
// register defaults and clears all counters and valid flags; the phase ring contents are left as they are.
`default_nettype none

module spatial_diff_phase_decimator
  import spd_pkg::*;
#(
  parameter int MAX_DIFF = MAX_DIFF_DEF,
  localparam int PW = (MAX_DIFF > 1) ? $clog2(MAX_DIFF) : 1
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spd_in_if.sink    in_ch,
  spd_out_if.source out_ch,
  spd_cfg_if.sink   cfg_ch
);

  logic               accept;
  logic               in_ready;
  logic               restart;
  geom_t              geom;
  logic               hit;
  meta_t              meta;
  logic [PW-1:0]      waddr;
  logic [PW-1:0]      raddr;
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] old_phase;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign accept       = in_ch.valid && in_ready;
  assign phase        = in_ch.sample_word[SAMPLE_W-1 -: PHASE_W];

  spd_cfg_regs #(.MAX_DIFF(MAX_DIFF)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_ch.valid),
    .wr_idx  (cfg_ch.index),
    .wr_data (cfg_ch.data),
    .restart (restart),
    .geom    (geom)
  );

  spd_ctrl #(.MAX_DIFF(MAX_DIFF)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .restart (restart),
    .geom    (geom),
    .hit     (hit),
    .meta    (meta),
    .waddr   (waddr),
    .raddr   (raddr)
  );

  spd_ring #(.MAX_DIFF(MAX_DIFF)) u_ring (
    .clk   (clk),
    .en    (accept),
    .waddr (waddr),
    .wdata (phase),
    .raddr (raddr),
    .rdata (old_phase)
  );

  spd_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .hit       (hit),
    .meta      (meta),
    .phase     (phase),
    .old_phase (old_phase),
    .in_ready  (in_ready),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/spd_checker.sv =====
`default_nettype none

module spd_checker
  import spd_pkg::*;
(
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [DIFF_W-1:0] out_diff_phase,
  input wire logic [ROW_W-1:0]         out_row,
  input wire logic [COL_W-1:0]         out_column_index,
  input wire logic                     out_frame_last
);

  // Reset empties the result register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result always comes from an accepted sample, by way of the stage-one register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching sample beat");

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_diff_phase) && $stable(out_row) &&
      $stable(out_column_index) && $stable(out_frame_last))
    else $error("result payload changed while stalled");

endmodule

bind spatial_diff_phase_decimator spd_checker u_spd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_diff_phase   (out_ch.diff_phase),
  .out_row          (out_ch.out_row),
  .out_column_index (out_ch.column_index),
  .out_frame_last   (out_ch.frame_last)
);

`default_nettype wire
